FILE: rtl/ealu_pkg.sv
`timescale 1ns / 1ps

package ealu_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_ADDHL = 5'd10,
        OP_ADDSP = 5'd11,
        OP_RLC   = 5'd12,
        OP_RRC   = 5'd13,
        OP_RL    = 5'd14,
        OP_RR    = 5'd15,
        OP_SLA   = 5'd16,
        OP_SRA   = 5'd17,
        OP_SWAP  = 5'd18,
        OP_SRL   = 5'd19
    } t_op;

    // Flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // One input item
    typedef struct packed {
        logic [4:0]  operation;
        logic [7:0]  acc;
        logic [15:0] operand;
        logic [15:0] pair_value;
        logic [3:0]  flags_in;
    } t_req;

    // One result item
    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } t_rsp;

endpackage

FILE: rtl/ealu_in_if.sv
`timescale 1ns / 1ps

interface ealu_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  operation;
    logic [7:0]  acc;
    logic [15:0] operand;
    logic [15:0] pair_value;
    logic [3:0]  flags_in;

    modport source (
        output valid, operation, acc, operand, pair_value, flags_in,
        input  ready
    );
    modport sink (
        input  valid, operation, acc, operand, pair_value, flags_in,
        output ready
    );
endinterface

FILE: rtl/ealu_out_if.sv
`timescale 1ns / 1ps

interface ealu_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] result;
    logic [3:0]  flags_out;

    modport source (
        output valid, result, flags_out,
        input  ready
    );
    modport sink (
        input  valid, result, flags_out,
        output ready
    );
endinterface

FILE: rtl/eight_bit_alu_with_flags_top.sv
// An accepted item is registered in the input stage and, after the ALU core, in the result stage.
// Throughput: one item per cycle unless stalled; the ALU is a single pass between the two registers.
// Ready deasserts only while both registers hold items and the result is not taken.
// Reset: synchronous, active low; clears the valid bits of both stages, payload unaffected.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ealu_in_if.sink     i_in,
    ealu_out_if.source  o_out
);
    import ealu_pkg::*;

    logic  r_s1_valid;
    t_req  r_s1_req;
    logic  r_s2_valid;
    t_rsp  r_s2_rsp;
    t_rsp  n_s2_rsp;
    logic  s2_adv;
    logic  s1_adv;

    // Stall chain from the output back to the input
    assign s2_adv     = !r_s2_valid || o_out.ready;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign i_in.ready = s1_adv;

    // Stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= i_in.valid;
            end
            if (s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    // Capture the incoming item
    always_ff @(posedge i_clk) begin
        if (s1_adv && i_in.valid) begin
            r_s1_req.operation  <= i_in.operation;
            r_s1_req.acc        <= i_in.acc;
            r_s1_req.operand    <= i_in.operand;
            r_s1_req.pair_value <= i_in.pair_value;
            r_s1_req.flags_in   <= i_in.flags_in;
        end
    end

    ealu_core u_core (
        .i_req (r_s1_req),
        .o_rsp (n_s2_rsp)
    );

    // Capture the result
    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_s2_rsp <= n_s2_rsp;
        end
    end

    assign o_out.valid     = r_s2_valid;
    assign o_out.result    = r_s2_rsp.result;
    assign o_out.flags_out = r_s2_rsp.flags_out;

    // Reset empties the result stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_s2_valid)
        else $error("result valid after reset");

    // An accepted item reaches the input register
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_s1_valid)
        else $error("accepted item lost");

    // A full pipe under stall keeps both items
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s2_valid && !o_out.ready) |=> (r_s1_valid && r_s2_valid))
        else $error("item dropped during stall");

    // A stalled result holds its value
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !o_out.ready) |=> $stable(r_s2_rsp))
        else $error("result changed during stall");

endmodule

FILE: rtl/ealu_core.sv
`timescale 1ns / 1ps

module ealu_core (
    input  ealu_pkg::t_req i_req,
    output ealu_pkg::t_rsp o_rsp
);
    import ealu_pkg::*;

    logic [7:0]  a;
    logic [7:0]  v;
    logic [15:0] w;
    logic [15:0] pair;
    logic [3:0]  fin;
    logic        cin;
    logic        c_arith;
    logic [8:0]  sum8;
    logic [8:0]  dif8;
    logic [16:0] sum16;
    logic [15:0] sp_sum;
    logic [4:0]  sp_lo4;
    logic [8:0]  sp_lo8;
    logic [15:0] res;
    logic        z;
    logic        n;
    logic        h;
    logic        c;
    logic        keep;

    assign a    = i_req.acc;
    assign w    = i_req.operand;
    assign v    = w[7:0];
    assign pair = i_req.pair_value;
    assign fin  = i_req.flags_in;
    assign cin  = fin[FLAG_C];

    // Carry or borrow in only for the with-carry forms
    assign c_arith = ((i_req.operation == OP_ADC) || (i_req.operation == OP_SBC)) ? cin : 1'b0;

    // Adders; the byte sum and difference are shared by several operations
    assign sum8   = {1'b0, a} + {1'b0, v} + {8'd0, c_arith};
    assign dif8   = {1'b0, a} - {1'b0, v} - {8'd0, c_arith};
    assign sum16  = {1'b0, pair} + {1'b0, w};
    assign sp_sum = pair + {{8{v[7]}}, v};
    assign sp_lo4 = {1'b0, pair[3:0]} + {1'b0, v[3:0]};
    assign sp_lo8 = {1'b0, pair[7:0]} + {1'b0, v};

    // Select result and flags by operation
    always_comb begin
        res  = 16'd0;
        n    = 1'b0;
        h    = 1'b0;
        c    = 1'b0;
        z    = 1'b0;
        keep = 1'b0;
        case (i_req.operation)
            OP_ADD, OP_ADC: begin
                res = {8'd0, sum8[7:0]};
                h   = (a[4] ^ v[4] ^ sum8[4]);
                c   = sum8[8];
            end
            OP_SUB, OP_SBC, OP_CP: begin
                res = (i_req.operation == OP_CP) ? {8'd0, a} : {8'd0, dif8[7:0]};
                n   = 1'b1;
                h   = (a[4] ^ v[4] ^ dif8[4]);
                c   = dif8[8];
            end
            OP_AND: begin
                res = {8'd0, a & v};
                h   = 1'b1;
            end
            OP_XOR:  res = {8'd0, a ^ v};
            OP_OR:   res = {8'd0, a | v};
            OP_INC: begin
                res = {8'd0, v + 8'd1};
                h   = (v[3:0] == 4'hF);
                c   = cin;
            end
            OP_DEC: begin
                res = {8'd0, v - 8'd1};
                n   = 1'b1;
                h   = (v[3:0] == 4'h0);
                c   = cin;
            end
            OP_ADDHL: begin
                res = sum16[15:0];
                h   = (pair[12] ^ w[12] ^ sum16[12]);
                c   = sum16[16];
            end
            OP_ADDSP: begin
                res = sp_sum;
                h   = sp_lo4[4];
                c   = sp_lo8[8];
            end
            OP_RLC: begin
                res = {8'd0, v[6:0], v[7]};
                c   = v[7];
            end
            OP_RRC: begin
                res = {8'd0, v[0], v[7:1]};
                c   = v[0];
            end
            OP_RL: begin
                res = {8'd0, v[6:0], cin};
                c   = v[7];
            end
            OP_RR: begin
                res = {8'd0, cin, v[7:1]};
                c   = v[0];
            end
            OP_SLA: begin
                res = {8'd0, v[6:0], 1'b0};
                c   = v[7];
            end
            OP_SRA: begin
                res = {8'd0, v[7], v[7:1]};
                c   = v[0];
            end
            OP_SWAP: res = {8'd0, v[3:0], v[7:4]};
            OP_SRL: begin
                res = {8'd0, 1'b0, v[7:1]};
                c   = v[0];
            end
            default: keep = 1'b1;
        endcase

        // Zero flag: held for ADD HL, cleared for ADD SP, from the difference for CP, else from the byte result
        case (i_req.operation)
            OP_ADDHL: z = fin[FLAG_Z];
            OP_ADDSP: z = 1'b0;
            OP_CP:    z = (dif8[7:0] == 8'd0);
            default:  z = (res[7:0] == 8'd0);
        endcase
    end

    // Undefined codes pass the flags through
    assign o_rsp.result    = res;
    assign o_rsp.flags_out = keep ? fin : {z, n, h, c};

endmodule
